FILE: src/mcsl_pkg.sv
// Shared types, widths and helpers for the mip chain subresource layout block.
// No dependencies; imported by every module under src.
package mcsl_pkg;

  localparam int unsigned MaxMips = 15;

  localparam int unsigned KindW    = 2;
  localparam int unsigned DimW     = 15;
  localparam int unsigned DepthW   = 12;
  localparam int unsigned ElemW    = 6;
  localparam int unsigned MipsW    = 4;
  localparam int unsigned LayersW  = 12;
  localparam int unsigned PlaneW   = 46;
  localparam int unsigned LevelW   = 4;
  localparam int unsigned LayerW   = 11;
  localparam int unsigned OffW     = 58;
  localparam int unsigned SizeW    = 45;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 46;

  localparam int unsigned MipCmpW    = LevelW + 1;
  localparam int unsigned LvlStages  = MaxMips + 2;
  localparam int unsigned CntW       = $clog2(LvlStages + 1);
  localparam int unsigned WhW        = 2 * DimW;
  localparam int unsigned WhdW       = WhW + DepthW;
  localparam int unsigned SumW       = WhdW + $clog2(MaxMips);
  localparam int unsigned SumEW      = SumW + ElemW;
  localparam int unsigned SizeEW     = WhdW + ElemW;
  localparam int unsigned PlaneLoW   = PlaneW / 2;
  localparam int unsigned PlaneHiW   = PlaneW - PlaneLoW;
  localparam int unsigned LpW        = LayerW + PlaneW;
  localparam int unsigned TailStages = 3;
  localparam int unsigned Latency    = 1 + LvlStages + TailStages;

  typedef enum logic [KindW-1:0] {
    KIND_1D = 2'd0,
    KIND_2D = 2'd1,
    KIND_3D = 2'd2
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KIND   = 3'd0,
    CFG_WIDTH  = 3'd1,
    CFG_HEIGHT = 3'd2,
    CFG_DEPTH  = 3'd3,
    CFG_ELEM   = 3'd4,
    CFG_MIPS   = 3'd5,
    CFG_LAYERS = 3'd6,
    CFG_PLANE  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [KindW-1:0]   image_kind;
    logic [DimW-1:0]    base_width;
    logic [DimW-1:0]    base_height;
    logic [DepthW-1:0]  base_depth;
    logic [ElemW-1:0]   element_bytes;
    logic [MipsW-1:0]   mip_count;
    logic [LayersW-1:0] layer_count;
    logic [PlaneW-1:0]  plane_bytes;
  } cfg_t;

  // Item state through the level chain. At level stage k: w/h/d are level k,
  // wh/d_prev are level k-1, whd is level k-2 (cnt == k).
  typedef struct packed {
    logic [LevelW-1:0] mip;
    logic [LayerW-1:0] layer;
    logic              ok;
    logic [CntW-1:0]   cnt;
    logic [DimW-1:0]   w;
    logic [DimW-1:0]   h;
    logic [DepthW-1:0] d;
    logic [WhW-1:0]    wh;
    logic [DepthW-1:0] d_prev;
    logic [WhdW-1:0]   whd;
    logic [SumW-1:0]   sum;
    logic [WhdW-1:0]   sel;
  } lvl_t;

  typedef struct packed {
    logic              valid_res;
    logic [OffW-1:0]   byte_offset;
    logic [SizeW-1:0]  byte_size;
    logic [DimW-1:0]   row_pitch;
    logic [PlaneW-1:0] array_pitch;
    logic [PlaneW-1:0] depth_pitch;
  } res_t;

  function automatic logic [DimW-1:0] halve(input logic [DimW-1:0] x);
    return (x > DimW'(1)) ? (x >> 1) : x;
  endfunction

endpackage

FILE: src/mip_chain_subresource_layout_core.sv
// Pipeline from start to done_o: entry register, one stage per mip level plus two
// for the level product, then three stages for scaling and layer offset.
// Throughput: one item per cycle; busy stays low and nothing stalls, the receiver
// cannot hold results off. Reset clears all pipeline valid bits and loads the
// configuration registers with their defaults. Top level; uses mcsl_pkg,
// mcsl_level and mcsl_tail.
module mip_chain_subresource_layout_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cfg_we_i,
  input  logic [mcsl_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mcsl_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic [mcsl_pkg::LevelW-1:0]   mip_level_i,
  input  logic [mcsl_pkg::LayerW-1:0]   array_layer_i,
  output logic                          done_o,
  output logic                          valid_res_o,
  output logic [mcsl_pkg::OffW-1:0]     byte_offset_o,
  output logic [mcsl_pkg::SizeW-1:0]    byte_size_o,
  output logic [mcsl_pkg::DimW-1:0]     row_pitch_o,
  output logic [mcsl_pkg::PlaneW-1:0]   array_pitch_o,
  output logic [mcsl_pkg::PlaneW-1:0]   depth_pitch_o
);
  import mcsl_pkg::*;

  cfg_t                cfg_q;
  logic                accept;
  logic [MipCmpW-1:0]  mips_ext, levels;
  lvl_t                ent_d;
  logic                ent_valid_q;
  lvl_t                ent_q;
  lvl_t                chain [LvlStages+1];
  logic [LvlStages:0]  chain_vld;
  res_t                res;

  // pipeline never stalls
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{image_kind:    KIND_2D,
                 base_width:    DimW'(1),
                 base_height:   DimW'(1),
                 base_depth:    DepthW'(1),
                 element_bytes: ElemW'(4),
                 mip_count:     MipsW'(1),
                 layer_count:   LayersW'(1),
                 plane_bytes:   '0};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KIND:   cfg_q.image_kind    <= cfg_wdata_i[KindW-1:0];
        CFG_WIDTH:  cfg_q.base_width    <= cfg_wdata_i[DimW-1:0];
        CFG_HEIGHT: cfg_q.base_height   <= cfg_wdata_i[DimW-1:0];
        CFG_DEPTH:  cfg_q.base_depth    <= cfg_wdata_i[DepthW-1:0];
        CFG_ELEM:   cfg_q.element_bytes <= cfg_wdata_i[ElemW-1:0];
        CFG_MIPS:   cfg_q.mip_count     <= cfg_wdata_i[MipsW-1:0];
        CFG_LAYERS: cfg_q.layer_count   <= cfg_wdata_i[LayersW-1:0];
        CFG_PLANE:  cfg_q.plane_bytes   <= cfg_wdata_i[PlaneW-1:0];
      endcase
    end
  end

  always_comb begin
    mips_ext = MipCmpW'(cfg_q.mip_count);
    levels   = (mips_ext < MipCmpW'(MaxMips)) ? mips_ext : MipCmpW'(MaxMips);

    ent_d       = '0;
    ent_d.mip   = mip_level_i;
    ent_d.layer = array_layer_i;
    ent_d.ok    = (MipCmpW'(mip_level_i) < levels)
                  && (LayersW'(array_layer_i) < cfg_q.layer_count);
    ent_d.w     = cfg_q.base_width;
    ent_d.h     = DimW'(1);
    ent_d.d     = DepthW'(1);
    // unused dims forced to 1, reserved kind gives zero sizes
    unique case (cfg_q.image_kind)
      KIND_1D: ;
      KIND_2D: ent_d.h = cfg_q.base_height;
      KIND_3D: begin
        ent_d.h = cfg_q.base_height;
        ent_d.d = cfg_q.base_depth;
      end
      default: ent_d.w = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q <= 1'b0;
    end else begin
      ent_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign chain[0]     = ent_q;
  assign chain_vld[0] = ent_valid_q;

  for (genvar g = 0; g < LvlStages; g++) begin : g_lvl
    mcsl_level u_lvl (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_vld[g]),
      .lvl_i   (chain[g]),
      .valid_o (chain_vld[g+1]),
      .lvl_o   (chain[g+1])
    );
  end

  mcsl_tail u_tail (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (chain_vld[LvlStages]),
    .lvl_i   (chain[LvlStages]),
    .cfg_i   (cfg_q),
    .done_o  (done_o),
    .res_o   (res)
  );

  assign valid_res_o   = res.valid_res;
  assign byte_offset_o = res.byte_offset;
  assign byte_size_o   = res.byte_size;
  assign row_pitch_o   = res.row_pitch;
  assign array_pitch_o = res.array_pitch;
  assign depth_pitch_o = res.depth_pitch;

endmodule

FILE: src/mcsl_level.sv
// One mip level step of the layout chain: halves the extent, forms the
// partial products and accumulates earlier level sizes. Uses mcsl_pkg.
module mcsl_level (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  mcsl_pkg::lvl_t      lvl_i,
  output logic                valid_o,
  output mcsl_pkg::lvl_t      lvl_o
);
  import mcsl_pkg::*;

  logic            valid_q;
  lvl_t            lvl_d, lvl_q;
  logic [CntW-1:0] tgt;

  always_comb begin
    tgt          = CntW'(lvl_i.mip) + CntW'(2);
    lvl_d        = lvl_i;
    lvl_d.cnt    = lvl_i.cnt + CntW'(1);
    lvl_d.w      = halve(lvl_i.w);
    lvl_d.h      = halve(lvl_i.h);
    lvl_d.d      = DepthW'(halve(DimW'(lvl_i.d)));
    lvl_d.wh     = WhW'(lvl_i.w) * WhW'(lvl_i.h);
    lvl_d.d_prev = lvl_i.d;
    lvl_d.whd    = WhdW'(lvl_i.wh) * WhdW'(lvl_i.d_prev);
    if (lvl_i.cnt < tgt) begin
      lvl_d.sum = lvl_i.sum + SumW'(lvl_i.whd);
    end
    if (lvl_i.cnt == tgt) begin
      lvl_d.sel = lvl_i.whd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q <= lvl_d;
  end

  assign valid_o = valid_q;
  assign lvl_o   = lvl_q;

endmodule

FILE: src/mcsl_tail.sv
// Final three stages: scales by element size, adds the layer offset and
// forms the registered result. Uses mcsl_pkg.
module mcsl_tail (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  mcsl_pkg::lvl_t lvl_i,
  input  mcsl_pkg::cfg_t cfg_i,
  output logic           done_o,
  output mcsl_pkg::res_t res_o
);
  import mcsl_pkg::*;

  logic                         v1_q, v2_q, done_q;
  logic                         ok1_q, ok2_q;
  logic [LayerW+PlaneLoW-1:0]   lo1_q;
  logic [LayerW+PlaneHiW-1:0]   hi1_q;
  logic [SumEW-1:0]             sume1_q, sume2_q;
  logic [SizeEW-1:0]            sizee1_q, sizee2_q;
  logic [LpW-1:0]               lp2_q;
  res_t                         res_d, res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= valid_i;
      v2_q   <= v1_q;
      done_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ok1_q    <= lvl_i.ok;
    lo1_q    <= (LayerW+PlaneLoW)'(lvl_i.layer)
                * (LayerW+PlaneLoW)'(cfg_i.plane_bytes[PlaneLoW-1:0]);
    hi1_q    <= (LayerW+PlaneHiW)'(lvl_i.layer)
                * (LayerW+PlaneHiW)'(cfg_i.plane_bytes[PlaneW-1:PlaneLoW]);
    sume1_q  <= SumEW'(lvl_i.sum) * SumEW'(cfg_i.element_bytes);
    sizee1_q <= SizeEW'(lvl_i.sel) * SizeEW'(cfg_i.element_bytes);

    ok2_q    <= ok1_q;
    lp2_q    <= (LpW'(hi1_q) << PlaneLoW) + LpW'(lo1_q);
    sume2_q  <= sume1_q;
    sizee2_q <= sizee1_q;

    res_q    <= res_d;
  end

  always_comb begin
    res_d = '0;
    if (ok2_q) begin
      res_d.valid_res   = 1'b1;
      res_d.byte_offset = OffW'(lp2_q) + OffW'(sume2_q);
      res_d.byte_size   = sizee2_q[SizeW-1:0];
      res_d.row_pitch   = cfg_i.base_width;
      res_d.array_pitch = cfg_i.plane_bytes;
      res_d.depth_pitch = (cfg_i.image_kind == KIND_3D) ? cfg_i.plane_bytes : '0;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

FILE: src/mcsl_checker.sv
// Port-level checks for mip_chain_subresource_layout_core, bound to the top level.
// Uses mcsl_pkg.
module mcsl_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic [mcsl_pkg::LevelW-1:0]   mip_level_i,
  input logic [mcsl_pkg::LayerW-1:0]   array_layer_i,
  input logic                          done_o,
  input logic                          valid_res_o,
  input logic [mcsl_pkg::OffW-1:0]     byte_offset_o,
  input logic [mcsl_pkg::SizeW-1:0]    byte_size_o,
  input logic [mcsl_pkg::DimW-1:0]     row_pitch_o,
  input logic [mcsl_pkg::PlaneW-1:0]   array_pitch_o,
  input logic [mcsl_pkg::PlaneW-1:0]   depth_pitch_o
);
  import mcsl_pkg::*;

  a_item_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Latency done_o)
    else $error("accepted item gave no result at fixed latency");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !valid_res_o) |-> (byte_offset_o == '0 && byte_size_o == '0
      && row_pitch_o == '0 && array_pitch_o == '0 && depth_pitch_o == '0))
    else $error("out of range item has nonzero fields");

  a_depth_pitch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (depth_pitch_o == '0 || depth_pitch_o == array_pitch_o))
    else $error("depth pitch neither zero nor plane size");

  a_first_sub: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && valid_res_o && $past(mip_level_i, Latency) == '0
      && $past(array_layer_i, Latency) == '0) |-> byte_offset_o == '0)
    else $error("level zero of layer zero not at offset zero");

endmodule

bind mip_chain_subresource_layout_core mcsl_checker u_mcsl_checker (.*);

FILE: tb/mip_chain_subresource_layout_core_test.sv
// Self-checking testbench for mip_chain_subresource_layout_core: directed layouts, then
// random layouts and requests, each result checked against a built-in layout predictor.
// Depends on mcsl_pkg and the block's RTL under src.
module mip_chain_subresource_layout_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mcsl_pkg::*;

  localparam logic [KindW-1:0] KindUnused = 2'd3;
  localparam int unsigned CycleLimit = 200000;

  class layout_scoreboard;
    cfg_t regs;
    res_t pending_layouts[$];
    int unsigned errors;

    function new();
      regs = '0;
      regs.image_kind = KIND_2D;
      regs.base_width = 1;
      regs.base_height = 1;
      regs.base_depth = 1;
      regs.element_bytes = 4;
      regs.mip_count = 1;
      regs.layer_count = 1;
      errors = 0;
    endfunction

    function void set_register(cfg_idx_e idx, logic [CfgDataW-1:0] value);
      case (idx)
        CFG_KIND:   regs.image_kind = value[KindW-1:0];
        CFG_WIDTH:  regs.base_width = value[DimW-1:0];
        CFG_HEIGHT: regs.base_height = value[DimW-1:0];
        CFG_DEPTH:  regs.base_depth = value[DepthW-1:0];
        CFG_ELEM:   regs.element_bytes = value[ElemW-1:0];
        CFG_MIPS:   regs.mip_count = value[MipsW-1:0];
        CFG_LAYERS: regs.layer_count = value[LayersW-1:0];
        CFG_PLANE:  regs.plane_bytes = value[PlaneW-1:0];
        default: ;
      endcase
    endfunction

    function bit [63:0] mip_bytes(int unsigned level);
      bit [63:0] w, h, d, e;
      w = 64'(regs.base_width);
      h = 64'(regs.base_height);
      d = 64'(regs.base_depth);
      e = 64'(regs.element_bytes);
      for (int unsigned i = 0; i < level; i++) begin
        if (w > 1) w = w >> 1;
        if (h > 1 && regs.image_kind != KIND_1D) h = h >> 1;
        if (d > 1 && regs.image_kind == KIND_3D) d = d >> 1;
      end
      case (regs.image_kind)
        KIND_1D: return w * e;
        KIND_2D: return w * h * e;
        KIND_3D: return w * h * d * e;
        default: return '0;
      endcase
    endfunction

    function void note_request(logic [LevelW-1:0] level, logic [LayerW-1:0] layer);
      res_t r;
      bit [63:0] offset, size;
      int unsigned levels;
      r = '0;
      levels = (32'(regs.mip_count) < MaxMips) ? 32'(regs.mip_count) : MaxMips;
      if (32'(level) < levels && LayersW'(layer) < regs.layer_count) begin
        offset = 64'(layer) * 64'(regs.plane_bytes);
        for (int unsigned i = 0; i < 32'(level); i++) offset += mip_bytes(i);
        size = mip_bytes(32'(level));
        r.valid_res = 1'b1;
        r.byte_offset = offset[OffW-1:0];
        r.byte_size = size[SizeW-1:0];
        r.row_pitch = regs.base_width;
        r.array_pitch = regs.plane_bytes;
        r.depth_pitch = (regs.image_kind == KIND_3D) ? regs.plane_bytes : '0;
      end
      pending_layouts = {pending_layouts, r};
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending_layouts.size() == 0) begin
        $error("result with no request pending");
        errors++;
        return;
      end
      want = pending_layouts.pop_front();
      if (got.valid_res !== want.valid_res) begin
        $error("valid_res: expected %0d, got %0d", want.valid_res, got.valid_res);
        errors++;
      end
      if (got.byte_offset !== want.byte_offset) begin
        $error("byte_offset: expected %0d, got %0d", want.byte_offset, got.byte_offset);
        errors++;
      end
      if (got.byte_size !== want.byte_size) begin
        $error("byte_size: expected %0d, got %0d", want.byte_size, got.byte_size);
        errors++;
      end
      if (got.row_pitch !== want.row_pitch) begin
        $error("row_pitch: expected %0d, got %0d", want.row_pitch, got.row_pitch);
        errors++;
      end
      if (got.array_pitch !== want.array_pitch) begin
        $error("array_pitch: expected %0d, got %0d", want.array_pitch, got.array_pitch);
        errors++;
      end
      if (got.depth_pitch !== want.depth_pitch) begin
        $error("depth_pitch: expected %0d, got %0d", want.depth_pitch, got.depth_pitch);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic [LevelW-1:0]   mip_level_i = '0;
  logic [LayerW-1:0]   array_layer_i = '0;
  logic                done_o;
  logic                valid_res_o;
  logic [OffW-1:0]     byte_offset_o;
  logic [SizeW-1:0]    byte_size_o;
  logic [DimW-1:0]     row_pitch_o;
  logic [PlaneW-1:0]   array_pitch_o;
  logic [PlaneW-1:0]   depth_pitch_o;

  layout_scoreboard board;
  int unsigned idle_pct = 0;
  int unsigned cycle_count = 0;

  mip_chain_subresource_layout_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .mip_level_i   (mip_level_i),
    .array_layer_i (array_layer_i),
    .done_o        (done_o),
    .valid_res_o   (valid_res_o),
    .byte_offset_o (byte_offset_o),
    .byte_size_o   (byte_size_o),
    .row_pitch_o   (row_pitch_o),
    .array_pitch_o (array_pitch_o),
    .depth_pitch_o (depth_pitch_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("mip_chain_subresource_layout_core_test failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && done_o) begin
      board.check_result('{valid_res_o, byte_offset_o, byte_size_o, row_pitch_o,
                           array_pitch_o, depth_pitch_o});
    end
  end

  // Called at a rising edge; returns at the edge that accepts the item, start left high.
  task automatic send_request(logic [LevelW-1:0] level, logic [LayerW-1:0] layer);
    logic ok;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    mip_level_i <= level;
    array_layer_i <= layer;
    do begin
      @(negedge clk_i);
      ok = !busy;
      @(posedge clk_i);
    end while (!ok);
    board.note_request(level, layer);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    board.set_register(idx, value);
    @(posedge clk_i);
  endtask

  task automatic configure(logic [CfgDataW-1:0] kind, logic [CfgDataW-1:0] width,
                           logic [CfgDataW-1:0] height, logic [CfgDataW-1:0] depth,
                           logic [CfgDataW-1:0] elem, logic [CfgDataW-1:0] mips,
                           logic [CfgDataW-1:0] layers, logic [CfgDataW-1:0] plane);
    start <= 1'b0;
    @(posedge clk_i);
    while (board.pending_layouts.size() != 0) @(posedge clk_i);
    write_reg(CFG_KIND, kind);
    write_reg(CFG_WIDTH, width);
    write_reg(CFG_HEIGHT, height);
    write_reg(CFG_DEPTH, depth);
    write_reg(CFG_ELEM, elem);
    write_reg(CFG_MIPS, mips);
    write_reg(CFG_LAYERS, layers);
    write_reg(CFG_PLANE, plane);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly in range, with zero and all-ones register values now and then.
  function automatic logic [CfgDataW-1:0] pick_extent(int unsigned top, int unsigned all_ones);
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return CfgDataW'(all_ones);
      2, 3:    return CfgDataW'(top);
      4, 5, 6: return CfgDataW'($urandom_range(1, 8));
      default: return CfgDataW'($urandom_range(1, top));
    endcase
  endfunction

  task automatic random_layout();
    logic [CfgDataW-1:0] kind, plane;
    kind = ($urandom_range(0, 19) == 0) ? CfgDataW'(KindUnused)
                                        : CfgDataW'($urandom_range(0, 2));
    case ($urandom_range(0, 9))
      0:       plane = '0;
      1:       plane = '1;
      2:       plane = 46'd1 << 45;
      default: plane = 46'({$urandom, $urandom}) >> $urandom_range(0, 45);
    endcase
    configure(kind, pick_extent(16384, 32767), pick_extent(16384, 32767),
              pick_extent(2048, 4095), pick_extent(32, 63), pick_extent(15, 15),
              pick_extent(2048, 4095), plane);
  endtask

  task automatic random_request();
    int unsigned levels, layers;
    levels = (32'(board.regs.mip_count) < MaxMips) ? 32'(board.regs.mip_count) : MaxMips;
    layers = (32'(board.regs.layer_count) < 2048) ? 32'(board.regs.layer_count) : 2048;
    if (levels != 0 && layers != 0 && $urandom_range(0, 99) < 80)
      send_request(LevelW'($urandom_range(0, levels - 1)),
                   LayerW'($urandom_range(0, layers - 1)));
    else
      send_request(LevelW'($urandom_range(0, 15)), LayerW'($urandom_range(0, 2047)));
  endtask

  initial begin
    int unsigned idle_modes[3];
    idle_modes = '{17, 61, 0};
    board = new();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset layout: 2D 1x1, one mip, one layer
    send_request(0, 0);
    send_request(1, 0);
    send_request(0, 1);
    send_request(15, 2047);

    // largest in-range 3D image
    configure(CfgDataW'(KIND_3D), 16384, 16384, 2048, 32, 15, 2048, 46'd1 << 45);
    send_request(0, 0);
    send_request(14, 2047);
    send_request(7, 1024);
    send_request(15, 0);

    // 1D: height and depth never shrink
    configure(CfgDataW'(KIND_1D), 16384, 300, 5, 1, 15, 3, 40000);
    send_request(14, 2);
    send_request(3, 1);
    send_request(0, 3);

    // unused kind
    configure(CfgDataW'(KindUnused), 100, 100, 100, 8, 4, 2, 12345);
    send_request(3, 1);
    send_request(0, 0);

    // zero extent and zero element size
    configure(CfgDataW'(KIND_2D), 0, 7, 0, 0, 3, 2, 1000);
    send_request(2, 1);
    send_request(1, 0);

    // zero counts
    configure(CfgDataW'(KIND_2D), 64, 64, 1, 4, 0, 5, 500);
    send_request(0, 0);
    configure(CfgDataW'(KIND_2D), 64, 64, 1, 4, 4, 0, 500);
    send_request(0, 0);

    // all-ones register values
    configure(CfgDataW'(KIND_3D), 32767, 32767, 4095, 63, 15, 4095, '1);
    send_request(14, 2047);
    send_request(13, 2047);
    send_request(0, 2047);

    foreach (idle_modes[m]) begin
      idle_pct = idle_modes[m];
      repeat (10) begin
        random_layout();
        repeat (50) random_request();
      end
    end

    start <= 1'b0;
    while (board.pending_layouts.size() != 0) @(posedge clk_i);
    repeat (Latency + 8) @(posedge clk_i);

    if (board.errors == 0 && board.pending_layouts.size() == 0)
      $display("mip_chain_subresource_layout_core_test passed");
    else
      $display("mip_chain_subresource_layout_core_test failed");
    $finish;
  end

endmodule
